FILE: hw/rtl/pld_pkg.sv
// Shared types, constants and the arctangent table of the polyline deviation block.
`timescale 1ns / 1ps
`default_nettype none
package pld_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CORDIC_STEPS   = 21;
    localparam int ACC_W          = 25;
    localparam int HEAD_W         = 16;
    localparam int HEAD_MAX       = 18000;
    localparam int QUARTER_TURN   = 90 * 25600;
    localparam int CENTER_X_RST   = 320;
    localparam int CENTER_Y_RST   = 240;

    // Configuration register indexes.
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_SEL,
        S_DLD,
        S_DIV,
        S_DEND,
        S_DST1,
        S_DST2,
        S_HINIT,
        S_HITER,
        S_EMIT
    } t_state;

    // atan(2^-i) in 1/256 of a hundredth of a degree.
    function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] idx);
        logic signed [ACC_W-1:0] v;
        unique case (idx)
            5'd0:    v = 25'sd1152000;
            5'd1:    v = 25'sd680065;
            5'd2:    v = 25'sd359328;
            5'd3:    v = 25'sd182400;
            5'd4:    v = 25'sd91554;
            5'd5:    v = 25'sd45822;
            5'd6:    v = 25'sd22916;
            5'd7:    v = 25'sd11459;
            5'd8:    v = 25'sd5730;
            5'd9:    v = 25'sd2865;
            5'd10:   v = 25'sd1432;
            5'd11:   v = 25'sd716;
            5'd12:   v = 25'sd358;
            5'd13:   v = 25'sd179;
            5'd14:   v = 25'sd90;
            5'd15:   v = 25'sd45;
            5'd16:   v = 25'sd22;
            5'd17:   v = 25'sd11;
            5'd18:   v = 25'sd6;
            5'd19:   v = 25'sd3;
            5'd20:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pld_pt_if.sv
// Handshake channel that carries one polyline vertex item.
`timescale 1ns / 1ps
`default_nettype none
interface pld_pt_if
    import pld_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;

    modport source(output valid, output point_x, output point_y, output last_point,
                   input ready);
    modport sink(input valid, input point_x, input point_y, input last_point,
                 output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pld_res_if.sv
// Handshake channel that carries one deviation result item.
`timescale 1ns / 1ps
`default_nettype none
interface pld_res_if
    import pld_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic signed [COORD_BITS:0] lateral_offset;
    logic signed [HEAD_W-1:0]  heading_centideg;
    logic                      line_found;

    modport source(output valid, output lateral_offset, output heading_centideg,
                   output line_found, input ready);
    modport sink(input valid, input lateral_offset, input heading_centideg,
                 input line_found, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/polyline_lateral_and_heading_deviation.sv
// Top level of the polyline lateral offset and heading deviation block.
`timescale 1ns / 1ps
`default_nettype none
// Vertices of a polyline arrive one item at a time on i_pt. Each segment between
// consecutive vertices has the reference point (center_x, center_y) projected
// onto it with the parameter clamped to the segment, the projection truncated
// toward minus infinity to whole pixels, and the nearest projection is kept
// (the earliest one wins a tie). The first vertex with the smallest y is kept
// as well. The vertex marked last_point produces one result item: the lateral
// offset of the nearest projection from center_x and the heading toward the
// topmost vertex in rounded hundredths of a degree. A polyline with fewer than
// two vertices gives zeros with line_found low. After the result the polyline
// state is cleared; the center registers keep their values.
// Flow: the block works on one vertex at a time. The first vertex of a polyline
// is taken in idle alone. Every later vertex passes the multiply states S_MUL1 to
// S_MUL4, the select state S_SEL and, when the projection falls inside the
// segment, two bit-serial divisions (S_DLD, S_DIV, S_DEND), then the distance
// states S_DST1 and S_DST2 and the return to idle. The shared restoring divider
// gives one quotient bit per cycle. The last vertex adds CORDIC vectoring in
// S_HINIT and S_HITER and the result register load in S_EMIT. The result register
// frees the input side: a new polyline may start while a result waits.
// Center registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write them only while the block is idle, as the block does not
// enforce it; register 0 is center_x and register 1 is center_y.
module polyline_lateral_and_heading_deviation
    import pld_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_data,
    pld_pt_if.sink                     i_pt,
    pld_res_if.source                  o_res
);

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB + 1;       // coordinate difference, signed
    localparam int NW    = 2 * CB + 3;   // projection numerator, signed
    localparam int EW    = 2 * CB + 1;   // segment length squared
    localparam int BW    = 2 * CB + 2;   // best squared distance
    localparam int PW    = NW + DW;      // multiplier product
    localparam int QW    = 3 * CB + 1;   // dividend of the projection offset
    localparam int CW    = CB + 19;      // CORDIC vector components
    localparam int CMAX  = (CB > CORDIC_STEPS) ? CB : CORDIC_STEPS;
    localparam int CNT_W = $clog2(CMAX + 1);

    t_state r_state, n_state;

    logic [CB-1:0] r_cx, r_cy;
    logic [CB-1:0] r_prev_x, r_prev_y, r_top_x, r_top_y, r_best_px;
    logic [1:0]    r_count;
    logic [BW-1:0] r_best;
    logic          r_last;

    logic [CB-1:0]        r_ax, r_ay, r_bx, r_by, r_qx, r_qy;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [NW-1:0] r_num;
    logic [EW-1:0]        r_den;
    logic                 r_axis;
    logic [EW-1:0]        r_rem;
    logic [CB-1:0]        r_lo;
    logic [CB-1:0]        r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic [BW-1:0]        r_sq;

    logic signed [CW-1:0]    r_re, r_im;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_hzero;

    logic                      r_ov;
    logic signed [CB:0]        r_lat;
    logic signed [HEAD_W-1:0]  r_head;
    logic                      r_found;

    // Control decoded from the state.
    logic w_accept, w_emit_go;

    // Shared multiplier.
    logic signed [NW-1:0] w_ma;
    logic signed [DW-1:0] w_mb;
    logic signed [PW-1:0] w_prod;

    logic signed [DW-1:0] w_cxa, w_cya, w_ex, w_ey, w_dsel, w_dmag;
    logic signed [DW-1:0] w_hx, w_hy;
    logic [CB-1:0]        w_asel;
    logic [EW:0]          w_trial;
    logic                 w_qbit;
    logic signed [CB+1:0] w_off, w_qc;
    logic [BW-1:0]        w_dist;
    logic signed [CW-1:0] w_re_sh, w_im_sh;
    logic signed [ACC_W-1:0] w_hsum, w_hr;
    logic signed [HEAD_W-1:0] w_head;
    logic                 w_num_le0;

    assign w_cxa = $signed({1'b0, r_cx}) - $signed({1'b0, r_ax});
    assign w_cya = $signed({1'b0, r_cy}) - $signed({1'b0, r_ay});
    assign w_ex  = $signed({1'b0, r_cx}) - $signed({1'b0, r_qx});
    assign w_ey  = $signed({1'b0, r_cy}) - $signed({1'b0, r_qy});
    assign w_hx  = $signed({1'b0, r_top_x}) - $signed({1'b0, r_cx});
    assign w_hy  = $signed({1'b0, r_cy}) - $signed({1'b0, r_top_y});

    // The numerator is zero or negative: the projection clamps to the start.
    assign w_num_le0 = r_num[NW-1] || (r_num == '0);

    assign w_dsel = r_axis ? r_dy : r_dx;
    assign w_dmag = w_dsel[DW-1] ? -w_dsel : w_dsel;
    assign w_asel = r_axis ? r_ay : r_ax;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MUL1: begin
                w_ma = NW'(w_cxa);
                w_mb = r_dx;
            end
            S_MUL2: begin
                w_ma = NW'(w_cya);
                w_mb = r_dy;
            end
            S_MUL3: begin
                w_ma = NW'(r_dx);
                w_mb = r_dx;
            end
            S_MUL4: begin
                w_ma = NW'(r_dy);
                w_mb = r_dy;
            end
            S_DLD: begin
                w_ma = r_num;
                w_mb = w_dmag;
            end
            S_DST1: begin
                w_ma = NW'(w_ex);
                w_mb = w_ex;
            end
            S_DST2: begin
                w_ma = NW'(w_ey);
                w_mb = w_ey;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = PW'(w_ma) * PW'(w_mb);

    // One restoring division step; the dividend enters one bit per cycle.
    assign w_trial = {r_rem, r_lo[CB-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});

    // Floor of the signed quotient from the magnitude quotient and remainder.
    always_comb begin
        if (w_dsel[DW-1]) begin
            w_off = -$signed({2'b0, r_q}) - $signed({{(CB+1){1'b0}}, (r_rem != '0)});
        end else begin
            w_off = $signed({2'b0, r_q});
        end
        w_qc = $signed({2'b0, w_asel}) + w_off;
    end

    assign w_dist = r_sq + w_prod[BW-1:0];

    assign w_re_sh = r_re >>> r_cnt;
    assign w_im_sh = r_im >>> r_cnt;

    assign w_hsum = r_acc + ACC_W'(128);
    assign w_hr   = w_hsum >>> 8;

    always_comb begin
        if (r_hzero) begin
            w_head = '0;
        end else if (w_hr > ACC_W'(HEAD_MAX)) begin
            w_head = HEAD_W'(HEAD_MAX);
        end else if (w_hr < -ACC_W'(HEAD_MAX)) begin
            w_head = -HEAD_W'(HEAD_MAX);
        end else begin
            w_head = w_hr[HEAD_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_pt.valid) begin
                    if (r_count == 2'd0) begin
                        n_state = i_pt.last_point ? S_EMIT : S_IDLE;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_MUL4;
            S_MUL4: n_state = S_SEL;
            S_SEL: begin
                if (r_den == '0 || w_num_le0 || r_num >= $signed({2'b0, r_den})) begin
                    n_state = S_DST1;
                end else begin
                    n_state = S_DLD;
                end
            end
            S_DLD: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_W'(CB - 1)) begin
                    n_state = S_DEND;
                end
            end
            S_DEND: n_state = r_axis ? S_DST1 : S_DLD;
            S_DST1: n_state = S_DST2;
            S_DST2: n_state = r_last ? S_HINIT : S_IDLE;
            S_HINIT: n_state = S_HITER;
            S_HITER: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and control outputs.
    always_comb begin
        i_pt.ready = (r_state == S_IDLE);
        w_accept   = (r_state == S_IDLE) && i_pt.valid;
        w_emit_go  = (r_state == S_EMIT) && (!r_ov || o_res.ready);
    end

    assign o_res.valid            = r_ov;
    assign o_res.lateral_offset   = r_lat;
    assign o_res.heading_centideg = r_head;
    assign o_res.line_found       = r_found;

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cx      <= CB'(CENTER_X_RST);
            r_cy      <= CB'(CENTER_Y_RST);
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_top_x   <= '0;
            r_top_y   <= '0;
            r_best_px <= '0;
            r_count   <= '0;
            r_best    <= '1;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CENTER_X: r_cx <= i_cfg_data;
                    REG_CENTER_Y: r_cy <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_emit_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_accept) begin
                r_prev_x <= i_pt.point_x;
                r_prev_y <= i_pt.point_y;
                if (r_count != 2'd2) begin
                    r_count <= r_count + 2'd1;
                end
                if (r_count == 2'd0 || i_pt.point_y < r_top_y) begin
                    r_top_x <= i_pt.point_x;
                    r_top_y <= i_pt.point_y;
                end
            end
            if (r_state == S_DST2 && w_dist < r_best) begin
                r_best    <= w_dist;
                r_best_px <= r_qx;
            end
            if (w_emit_go) begin
                r_prev_x  <= '0;
                r_prev_y  <= '0;
                r_top_x   <= '0;
                r_top_y   <= '0;
                r_best_px <= '0;
                r_count   <= '0;
                r_best    <= '1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_pt.last_point;
            r_ax   <= r_prev_x;
            r_ay   <= r_prev_y;
            r_bx   <= i_pt.point_x;
            r_by   <= i_pt.point_y;
            r_dx   <= $signed({1'b0, i_pt.point_x}) - $signed({1'b0, r_prev_x});
            r_dy   <= $signed({1'b0, i_pt.point_y}) - $signed({1'b0, r_prev_y});
        end
        unique case (r_state)
            S_MUL1: r_num <= w_prod[NW-1:0];
            S_MUL2: r_num <= r_num + w_prod[NW-1:0];
            S_MUL3: r_den <= w_prod[EW-1:0];
            S_MUL4: r_den <= r_den + w_prod[EW-1:0];
            S_SEL: begin
                r_axis <= 1'b0;
                if (r_den == '0 || w_num_le0) begin
                    r_qx <= r_ax;
                    r_qy <= r_ay;
                end else if (r_num >= $signed({2'b0, r_den})) begin
                    r_qx <= r_bx;
                    r_qy <= r_by;
                end
            end
            S_DLD: begin
                r_rem <= w_prod[QW-1:CB];
                r_lo  <= w_prod[CB-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= w_qbit ? EW'(w_trial - {1'b0, r_den}) : w_trial[EW-1:0];
                r_lo  <= {r_lo[CB-2:0], 1'b0};
                r_q   <= {r_q[CB-2:0], w_qbit};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_DEND: begin
                if (r_axis) begin
                    r_qy <= w_qc[CB-1:0];
                end else begin
                    r_qx <= w_qc[CB-1:0];
                end
                r_axis <= 1'b1;
            end
            S_DST1: r_sq <= w_prod[BW-1:0];
            S_HINIT: begin
                r_cnt   <= '0;
                r_hzero <= (w_hx == '0) && (w_hy == '0);
                if (w_hy < 0) begin
                    if (w_hx >= 0) begin
                        r_re  <= CW'(w_hx) <<< 16;
                        r_im  <= CW'(-w_hy) <<< 16;
                        r_acc <= ACC_W'(QUARTER_TURN);
                    end else begin
                        r_re  <= CW'(-w_hx) <<< 16;
                        r_im  <= CW'(w_hy) <<< 16;
                        r_acc <= -ACC_W'(QUARTER_TURN);
                    end
                end else begin
                    r_re  <= CW'(w_hy) <<< 16;
                    r_im  <= CW'(w_hx) <<< 16;
                    r_acc <= '0;
                end
            end
            S_HITER: begin
                if (r_im > 0) begin
                    r_re  <= r_re + w_im_sh;
                    r_im  <= r_im - w_re_sh;
                    r_acc <= r_acc + atan_step(5'(r_cnt));
                end else begin
                    r_re  <= r_re - w_im_sh;
                    r_im  <= r_im + w_re_sh;
                    r_acc <= r_acc - atan_step(5'(r_cnt));
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
        if (w_emit_go) begin
            r_found <= (r_count == 2'd2);
            if (r_count == 2'd2) begin
                r_lat  <= $signed({1'b0, r_best_px}) - $signed({1'b0, r_cx});
                r_head <= w_head;
            end else begin
                r_lat  <= '0;
                r_head <= '0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: bench/polyline_lateral_and_heading_deviation_checker.sv
// Checker that predicts and compares the deviation result items of the polyline block.
`timescale 1ns / 1ps
`default_nettype none
module polyline_lateral_and_heading_deviation_checker
    import pld_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_data,
    pld_pt_if.sink                     i_pt_mon,
    pld_res_if.sink                    i_res_mon,
    output logic [31:0]                o_fail_count,
    output logic [31:0]                o_pending,
    output logic [31:0]                o_results_seen
);

    typedef struct packed {
        logic signed [COORD_BITS:0] lateral;
        logic signed [HEAD_W-1:0]   heading;
        logic                       found;
    } t_deviation;

    t_deviation deviation_queue[$];

    longint cen_x, cen_y;
    longint last_x, last_y, seg_count, best_dsq, best_x, apex_x, apex_y;

    function automatic longint shift_floor(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint div_floor(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint angle_table(int i);
        longint tab[21] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                            11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22,
                            11, 6, 3, 1};
        return tab[i];
    endfunction

    function automatic longint heading_of(longint hx, longint hy);
        longint re, im, acc, t, nre, nim, r;
        re = hy; im = hx; acc = 0;
        if (re == 0 && im == 0) return 0;
        if (re < 0) begin
            if (im >= 0) begin
                t = re; re = im; im = -t; acc = 90 * 25600;
            end else begin
                t = re; re = -im; im = t; acc = -90 * 25600;
            end
        end
        re = re * 65536;
        im = im * 65536;
        for (int i = 0; i < 21; i++) begin
            if (im > 0) begin
                nre = re + shift_floor(im, i); nim = im - shift_floor(re, i);
                acc += angle_table(i);
            end else begin
                nre = re - shift_floor(im, i); nim = im + shift_floor(re, i);
                acc -= angle_table(i);
            end
            re = nre; im = nim;
        end
        r = shift_floor(acc + 128, 8);
        if (r > HEAD_MAX) r = HEAD_MAX;
        if (r < -HEAD_MAX) r = -HEAD_MAX;
        return r;
    endfunction

    task automatic clear_polyline();
        last_x = 0; last_y = 0; seg_count = 0;
        best_dsq = (longint'(1) << (2 * COORD_BITS + 2)) - 1;
        best_x = 0; apex_x = 0; apex_y = 0;
    endtask

    task automatic take_vertex(longint px, longint py, bit fin);
        longint dx, dy, num, den, qx, qy, ex, ey, d;
        t_deviation e;
        if (seg_count == 0) begin
            apex_x = px; apex_y = py;
        end else begin
            dx = px - last_x; dy = py - last_y;
            num = (cen_x - last_x) * dx + (cen_y - last_y) * dy;
            den = dx * dx + dy * dy;
            qx = last_x; qy = last_y;
            if (den != 0 && num > 0) begin
                if (num >= den) begin
                    qx = px; qy = py;
                end else begin
                    qx = last_x + div_floor(num * dx, den);
                    qy = last_y + div_floor(num * dy, den);
                end
            end
            ex = cen_x - qx; ey = cen_y - qy;
            d = ex * ex + ey * ey;
            if (d < best_dsq) begin
                best_dsq = d; best_x = qx;
            end
            if (py < apex_y) begin
                apex_x = px; apex_y = py;
            end
        end
        last_x = px; last_y = py;
        if (seg_count < 2) seg_count++;
        if (fin) begin
            if (seg_count >= 2) begin
                e.lateral = (COORD_BITS + 1)'(best_x - cen_x);
                e.heading = HEAD_W'(heading_of(apex_x - cen_x, cen_y - apex_y));
                e.found   = 1'b1;
            end else begin
                e = '0;
            end
            deviation_queue.push_back(e);
            clear_polyline();
        end
    endtask

    assign o_pending = deviation_queue.size();

    always @(posedge i_clk) begin
        t_deviation exp_dev;
        if (!i_rst_n) begin
            cen_x = CENTER_X_RST; cen_y = CENTER_Y_RST;
            clear_polyline();
            deviation_queue.delete();
            o_fail_count <= 0;
            o_results_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CENTER_X) cen_x = i_cfg_data;
                else cen_y = i_cfg_data;
            end
            if (i_res_mon.valid && i_res_mon.ready) begin
                o_results_seen <= o_results_seen + 1;
                if (deviation_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result item: lat %0d head %0d found %0b",
                                 i_res_mon.lateral_offset, i_res_mon.heading_centideg,
                                 i_res_mon.line_found);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_dev = deviation_queue.pop_front();
                    if (exp_dev.lateral !== i_res_mon.lateral_offset
                        || exp_dev.heading !== i_res_mon.heading_centideg
                        || exp_dev.found !== i_res_mon.line_found) begin
                        if (o_fail_count < 10)
                            $display("Mismatch: exp lat %0d head %0d found %0b, got %0d %0d %0b",
                                     exp_dev.lateral, exp_dev.heading, exp_dev.found,
                                     i_res_mon.lateral_offset, i_res_mon.heading_centideg,
                                     i_res_mon.line_found);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_pt_mon.valid && i_pt_mon.ready)
                take_vertex(i_pt_mon.point_x, i_pt_mon.point_y, i_pt_mon.last_point);
        end
    end

endmodule
`default_nettype wire

FILE: bench/polyline_lateral_and_heading_deviation_tb.sv
// Top of the testbench: vertex stimulus, center settings and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module polyline_lateral_and_heading_deviation_tb;
    import pld_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int MAX_COORD = (1 << CB) - 1;
    // Worst case per vertex is the two divisions and the CORDIC vectoring, plus long sender and
    // receiver gaps; a few thousand vertices fit easily under this bound.
    localparam int CYCLE_LIMIT = 1000000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = REG_CENTER_X;
    logic [CB-1:0] i_cfg_data = '0;
    logic [31:0]   fail_count, pending, results_seen;
    int            cycle_count = 0;
    int            vertices_sent = 0;
    int            polylines_sent = 0;
    bit            stall_long;

    pld_pt_if  #(.COORD_BITS(CB)) pt_ch();
    pld_res_if #(.COORD_BITS(CB)) res_ch();

    polyline_lateral_and_heading_deviation #(.COORD_BITS(CB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_pt(pt_ch), .o_res(res_ch));

    polyline_lateral_and_heading_deviation_checker #(.COORD_BITS(CB)) chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_pt_mon(pt_ch), .i_res_mon(res_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run is cut off here if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Gap lengths: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls at random; during long stretches it never stalls,
    // so that back-to-back results are exercised too.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall_long = ($urandom_range(0, 199) == 0);
            if (stall_long) begin
                res_ch.ready = 1'b1;
                repeat ($urandom_range(50, 200)) @(negedge i_clk);
            end else begin
                res_ch.ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
                res_ch.ready = 1'b1;
            end
        end
    end

    // Presents one vertex item and holds it until the block takes it.
    task automatic send_vertex(int x, int y, bit fin);
        int g;
        g = gap_len();
        if (g > 0) begin
            pt_ch.valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        pt_ch.valid      = 1'b1;
        pt_ch.point_x    = x[CB-1:0];
        pt_ch.point_y    = y[CB-1:0];
        pt_ch.last_point = fin;
        do @(posedge i_clk); while (!pt_ch.ready);
        @(negedge i_clk);
        pt_ch.valid = 1'b0;
        vertices_sent++;
        if (fin) polylines_sent++;
    endtask

    // Registers change only with the block empty; the pause covers a
    // vertex still in flight that produces no result.
    task automatic set_center(int cx, int cy);
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = REG_CENTER_X; i_cfg_data = cx[CB-1:0];
        @(negedge i_clk);
        i_cfg_idx = REG_CENTER_Y; i_cfg_data = cy[CB-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // A random coordinate, sometimes pinned to an edge of the range.
    function automatic int rand_coord(int around, int spread);
        int r, v;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return MAX_COORD;
        v = around + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > MAX_COORD) v = MAX_COORD;
        return v;
    endfunction

    // A polyline of random length: one vertex now and then, otherwise 2 to 6 vertices.
    task automatic send_polyline(int cx, int cy);
        int n, spread;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
        spread = ($urandom_range(0, 3) == 0) ? MAX_COORD : $urandom_range(1, 300);
        for (int k = 0; k < n; k++) begin
            if (k > 0 && $urandom_range(0, 9) == 0)
                send_vertex(pt_ch.point_x, pt_ch.point_y, k == n - 1);
            else
                send_vertex(rand_coord(cx, spread), rand_coord(cy, spread), k == n - 1);
        end
    endtask

    initial begin
        int cx, cy;
        pt_ch.valid = 1'b0;
        pt_ch.point_x = '0;
        pt_ch.point_y = '0;
        pt_ch.last_point = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset center (320, 240).
        // A lone vertex gives the short-polyline result.
        send_vertex(100, 100, 1'b1);
        // Zero-length segment projects to its start.
        send_vertex(10, 20, 1'b0);
        send_vertex(10, 20, 1'b1);
        // Projection inside a segment, with negative slopes for floor rounding.
        send_vertex(0, 300, 1'b0);
        send_vertex(MAX_COORD, 0, 1'b1);
        // Segment ends clamp on both sides; ties keep the earlier one.
        send_vertex(400, 240, 1'b0);
        send_vertex(500, 240, 1'b0);
        send_vertex(400, 240, 1'b0);
        send_vertex(240, 240, 1'b1);
        // Top vertex straight below and at the center: heading from a left
        // half-plane vector and a zero vector.
        send_vertex(320, MAX_COORD, 1'b0);
        send_vertex(0, MAX_COORD, 1'b1);
        send_vertex(320, 240, 1'b0);
        send_vertex(320, 240, 1'b1);
        send_vertex(MAX_COORD, MAX_COORD, 1'b0);
        send_vertex(0, 0, 1'b1);

        // Extreme centers, each with a short directed polyline.
        set_center(0, 0);
        send_vertex(MAX_COORD, MAX_COORD, 1'b0);
        send_vertex(0, MAX_COORD, 1'b1);
        set_center(MAX_COORD, MAX_COORD);
        send_vertex(0, 0, 1'b0);
        send_vertex(MAX_COORD, 0, 1'b0);
        send_vertex(0, MAX_COORD, 1'b1);
        set_center(0, MAX_COORD);
        send_vertex(MAX_COORD, 0, 1'b0);
        send_vertex(0, 0, 1'b1);

        // Random part across several center settings.
        while (vertices_sent < 1020) begin
            if ($urandom_range(0, 39) == 0) begin
                cx = $urandom_range(0, MAX_COORD);
                cy = $urandom_range(0, MAX_COORD);
                set_center(cx, cy);
            end else begin
                cx = chk.cen_x;
                cy = chk.cen_y;
            end
            send_polyline(cx, cy);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("Sent %0d vertices in %0d polylines; %0d result items checked.",
                 vertices_sent, polylines_sent, results_seen);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
`default_nettype wire
